@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL of the sender window core.
// No dependencies; define ASSERT_OFF to drop all checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

@@ design/swcc_pkg.sv @@
// Shared widths, codes and divider interface types for the sender window core.
// No dependencies.
`default_nettype none
package swcc_pkg;
    localparam int RING_DEPTH_DEF = 32;
    localparam int SEQ_W  = 15;
    localparam int LEN_W  = 10;
    localparam int WIN_W  = 14;
    localparam int TMR_W  = 16;
    localparam int MOD_W  = 16;
    localparam int DIVD_W = 20;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    localparam logic [WIN_W-1:0] WIN_MAX = 14'h3FFF;
    localparam logic [MOD_W-1:0] MOD_MIN = 16'd2;
    localparam logic [MOD_W-1:0] MOD_MAX = 16'd32768;

    localparam logic [WIN_W-1:0] RST_INIT_WIN  = 14'd512;
    localparam logic [WIN_W-1:0] RST_INIT_THR  = 14'd5120;
    localparam logic [WIN_W-1:0] RST_WIN_CAP   = 14'd10240;
    localparam logic [LEN_W-1:0] RST_SEG_BYTES = 10'd512;
    localparam logic [WIN_W-1:0] RST_THR_FLOOR = 14'd1024;
    localparam logic [TMR_W-1:0] RST_TIMEOUT   = 16'd500;
    localparam logic [SEQ_W-1:0] RST_FIRST_SEQ = 15'd0;
    localparam logic [MOD_W-1:0] RST_SEQ_MOD   = 16'd25601;

    localparam logic [CFG_AW-1:0] CFG_INIT_WIN  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_INIT_THR  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_WIN_CAP   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_SEG_BYTES = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_THR_FLOOR = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_TIMEOUT   = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_FIRST_SEQ = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_SEQ_MOD   = 3'd7;

    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_ACK  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_HEAD = 2'd1;
    localparam logic [1:0] KIND_DUP  = 2'd2;
    localparam logic [1:0] KIND_POP  = 2'd3;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [MOD_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVD_W-1:0] quot;
        logic [MOD_W-1:0]  rem;
    } div_rsp_t;
endpackage
`default_nettype wire

@@ design/swcc_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// Depends on swcc_pkg for widths and the request/response structs.
`default_nettype none
module swcc_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire swcc_pkg::div_req_t req,
    output swcc_pkg::div_rsp_t      rsp
);
    localparam int CNT_W = $clog2(swcc_pkg::DIVD_W);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [swcc_pkg::DIVD_W-1:0] quot_reg, quot_next;
    logic [swcc_pkg::MOD_W-1:0]  rem_reg, rem_next;
    logic [swcc_pkg::MOD_W-1:0]  dvs_reg, dvs_next;
    logic [swcc_pkg::MOD_W:0]    part;
    logic [swcc_pkg::MOD_W:0]    diff;
    logic                        ge;

    assign part = {rem_reg, quot_reg[swcc_pkg::DIVD_W-1]};
    assign diff = part - {1'b0, dvs_reg};
    assign ge   = part >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(swcc_pkg::DIVD_W - 1);
            quot_next = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            quot_next = {quot_reg[swcc_pkg::DIVD_W-2:0], ge};
            rem_next  = ge ? diff[swcc_pkg::MOD_W-1:0] : part[swcc_pkg::MOD_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;
endmodule
`default_nettype wire

@@ design/sender_window_congestion_control_core.sv @@
// Sender window with Tahoe-style congestion control: FSM, in-flight ring memory.
// Depends on swcc_pkg, swcc_div and assert_macros.svh.
//
// Input channel s_*: one transaction per request. s_tuser carries op (send, ack,
// tick); s_tdata carries seg_len and ack_value. Result channel m_*: exactly one
// transaction per request with the admit result, ack classification, freed count,
// timeout flag, window, threshold and in-flight count.
// Config: cfg_we/cfg_addr/cfg_wdata write one register per cycle; the user must
// write only while idle; the block does not enforce it. Tick and no-op go straight
// to the result; send runs the window/segment divide, then the sequence modulo if
// admitted; ack runs the head-end modulo, then the congestion-avoidance growth
// divide or the walk for a cumulative ack. All division runs on one shared
// 20-step divider; the ring is walked one entry per cycle through the memory port.
// One request is processed at a time; a new one is taken while the last result
// still waits on m_tready. If the receiver stalls, the next result holds in the
// FSM until the output register frees.
// Reset: registers return to defaults, window/threshold/sequence load from them,
// the ring empties. Ring contents are not cleared.
`default_nettype none
`include "assert_macros.svh"
module sender_window_congestion_control_core #(
    parameter int RING_DEPTH = swcc_pkg::RING_DEPTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // [9:0] seg_len, [24:10] ack_value
    input  wire logic [31:0]                  s_tdata,
    // [1:0] op
    input  wire logic [1:0]                   s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // accepted, assigned_seq, ack_kind, freed_count, timed_out, window_now,
    // threshold_now, in_flight (lowest bit first)
    output logic [((47 + 2 * $clog2(RING_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,
    input  wire logic                         cfg_we,
    input  wire logic [swcc_pkg::CFG_AW-1:0]  cfg_addr,
    input  wire logic [swcc_pkg::CFG_DW-1:0]  cfg_wdata
);
    localparam int PTR_W   = $clog2(RING_DEPTH);
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int OUT_W   = ((47 + 2 * CNT_W + 7) / 8) * 8;
    localparam int ENT_W   = swcc_pkg::SEQ_W + swcc_pkg::LEN_W;
    localparam int SEQ_W   = swcc_pkg::SEQ_W;
    localparam int LEN_W   = swcc_pkg::LEN_W;
    localparam int WIN_W   = swcc_pkg::WIN_W;
    localparam int TMR_W   = swcc_pkg::TMR_W;
    localparam int MOD_W   = swcc_pkg::MOD_W;
    localparam int DIVD_W  = swcc_pkg::DIVD_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RING_DEPTH);
    localparam logic [PTR_W:0]   DEPTH_P = (PTR_W + 1)'(RING_DEPTH);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_SEND_DIV = 7'b0000010,
        ST_SEND_MOD = 7'b0000100,
        ST_ACK_MOD  = 7'b0001000,
        ST_GROW_DIV = 7'b0010000,
        ST_WALK     = 7'b0100000,
        ST_FINISH   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [WIN_W-1:0] init_win_reg, init_win_next;
    logic [WIN_W-1:0] init_thr_reg, init_thr_next;
    logic [WIN_W-1:0] win_cap_reg, win_cap_next;
    logic [LEN_W-1:0] seg_reg, seg_next;
    logic [WIN_W-1:0] thr_floor_reg, thr_floor_next;
    logic [TMR_W-1:0] tmo_reg, tmo_next;
    logic [SEQ_W-1:0] first_seq_reg, first_seq_next;
    logic [MOD_W-1:0] mod_reg, mod_next;

    logic [WIN_W-1:0] win_reg, win_next;
    logic [WIN_W-1:0] thr_reg, thr_next;
    logic [SEQ_W-1:0] nseq_reg, nseq_next;
    logic [TMR_W-1:0] tmr_reg, tmr_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [1:0]       op_reg, op_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [SEQ_W-1:0] ack_reg, ack_next;
    logic             acc_reg, acc_next;
    logic [SEQ_W-1:0] aseq_reg, aseq_next;
    logic [1:0]       kind_reg, kind_next;
    logic [CNT_W-1:0] freed_reg, freed_next;
    logic             tout_reg, tout_next;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;

    logic [ENT_W-1:0] ring_mem [RING_DEPTH];
    logic [ENT_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata;

    swcc_pkg::div_req_t div_req;
    swcc_pkg::div_rsp_t div_rsp;

    logic [LEN_W-1:0]   eff_seg;
    logic [MOD_W-1:0]   eff_mod;
    logic [SEQ_W-1:0]   rd_seq;
    logic [LEN_W-1:0]   rd_len;
    logic [PTR_W-1:0]   head_inc;
    logic [PTR_W:0]     tail_sum;
    logic [PTR_W-1:0]   tail;
    logic [WIN_W-1:0]   half_win;
    logic [WIN_W-1:0]   tmo_thr;
    logic [TMR_W-1:0]   tmr_inc;
    logic [WIN_W:0]     ss_sum;
    logic [WIN_W:0]     ca_sum;
    logic [WIN_W-1:0]   ca_inc;
    logic [2*LEN_W-1:0] seg_sq;
    logic               in_acc;

    swcc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign eff_seg  = (seg_reg == '0) ? LEN_W'(1) : seg_reg;
    assign eff_mod  = (mod_reg < swcc_pkg::MOD_MIN) ? swcc_pkg::MOD_MIN :
                      (mod_reg > swcc_pkg::MOD_MAX) ? swcc_pkg::MOD_MAX : mod_reg;
    assign rd_seq   = rd_data_reg[SEQ_W-1:0];
    assign rd_len   = rd_data_reg[ENT_W-1:SEQ_W];
    assign head_inc = (head_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_sum = {1'b0, head_reg} + (PTR_W + 1)'(cnt_reg);
    assign tail     = (tail_sum >= DEPTH_P) ? PTR_W'(tail_sum - DEPTH_P)
                                            : tail_sum[PTR_W-1:0];
    assign half_win = win_reg >> 1;
    assign tmo_thr  = (half_win > thr_floor_reg) ? half_win : thr_floor_reg;
    assign tmr_inc  = (tmr_reg == '1) ? tmr_reg : tmr_reg + 1'b1;
    assign ss_sum   = {1'b0, win_reg} + (WIN_W + 1)'(eff_seg);
    assign ca_inc   = (div_rsp.quot > DIVD_W'(swcc_pkg::WIN_MAX)) ? swcc_pkg::WIN_MAX
                                                                  : div_rsp.quot[WIN_W-1:0];
    assign ca_sum   = {1'b0, win_reg} + {1'b0, ca_inc};
    assign seg_sq   = eff_seg * eff_seg;
    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        init_win_next  = init_win_reg;
        init_thr_next  = init_thr_reg;
        win_cap_next   = win_cap_reg;
        seg_next       = seg_reg;
        thr_floor_next = thr_floor_reg;
        tmo_next       = tmo_reg;
        first_seq_next = first_seq_reg;
        mod_next       = mod_reg;
        win_next       = win_reg;
        thr_next       = thr_reg;
        nseq_next      = nseq_reg;
        tmr_next       = tmr_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        len_next       = len_reg;
        ack_next       = ack_reg;
        acc_next       = acc_reg;
        aseq_next      = aseq_reg;
        kind_next      = kind_reg;
        freed_next     = freed_reg;
        tout_next      = tout_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        mem_we         = 1'b0;
        mem_waddr      = tail;
        mem_wdata      = {len_reg, nseq_reg};
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    op_next    = s_tuser;
                    len_next   = s_tdata[LEN_W-1:0];
                    ack_next   = s_tdata[LEN_W+SEQ_W-1:LEN_W];
                    acc_next   = 1'b0;
                    aseq_next  = '0;
                    kind_next  = swcc_pkg::KIND_NONE;
                    freed_next = '0;
                    tout_next  = 1'b0;
                    state_next = ST_FINISH;
                    case (s_tuser)
                        swcc_pkg::OP_SEND: begin
                            div_req.start    = 1'b1;
                            div_req.dividend = DIVD_W'(win_reg);
                            div_req.divisor  = MOD_W'(eff_seg);
                            state_next       = ST_SEND_DIV;
                        end
                        swcc_pkg::OP_ACK: begin
                            if (cnt_reg != '0) begin
                                div_req.start    = 1'b1;
                                div_req.dividend = DIVD_W'(rd_seq) + DIVD_W'(rd_len);
                                div_req.divisor  = eff_mod;
                                state_next       = ST_ACK_MOD;
                            end
                        end
                        swcc_pkg::OP_TICK: begin
                            if (cnt_reg != '0) begin
                                tmr_next = tmr_inc;
                                if (tmr_inc >= tmo_reg) begin
                                    thr_next  = tmo_thr;
                                    win_next  = init_win_reg;
                                    tmr_next  = '0;
                                    tout_next = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SEND_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_FINISH;
                    if (len_reg != '0 && DIVD_W'(cnt_reg) < div_rsp.quot
                            && cnt_reg < DEPTH_C) begin
                        mem_we    = 1'b1;
                        cnt_next  = cnt_reg + 1'b1;
                        if (cnt_reg == '0) begin
                            tmr_next = '0;
                        end
                        acc_next  = 1'b1;
                        aseq_next = nseq_reg;
                        div_req.start    = 1'b1;
                        div_req.dividend = DIVD_W'(nseq_reg) + DIVD_W'(len_reg);
                        div_req.divisor  = eff_mod;
                        state_next       = ST_SEND_MOD;
                    end
                end
            end
            ST_SEND_MOD: begin
                if (div_rsp.done) begin
                    nseq_next  = div_rsp.rem[SEQ_W-1:0];
                    state_next = ST_FINISH;
                end
            end
            ST_ACK_MOD: begin
                if (div_rsp.done) begin
                    state_next = ST_FINISH;
                    if (MOD_W'(ack_reg) == div_rsp.rem) begin
                        head_next  = head_inc;
                        cnt_next   = cnt_reg - 1'b1;
                        freed_next = CNT_W'(1);
                        tmr_next   = '0;
                        kind_next  = swcc_pkg::KIND_HEAD;
                        if (win_reg < thr_reg) begin
                            win_next = (ss_sum > (WIN_W + 1)'(swcc_pkg::WIN_MAX))
                                       ? swcc_pkg::WIN_MAX : ss_sum[WIN_W-1:0];
                        end else if (win_reg < win_cap_reg) begin
                            div_req.start    = 1'b1;
                            div_req.dividend = DIVD_W'(seg_sq);
                            div_req.divisor  = (win_reg == '0) ? MOD_W'(1) : MOD_W'(win_reg);
                            state_next       = ST_GROW_DIV;
                        end
                    end else if (ack_reg == rd_seq) begin
                        kind_next = swcc_pkg::KIND_DUP;
                        if (tmr_reg >= tmo_reg) begin
                            thr_next  = tmo_thr;
                            win_next  = init_win_reg;
                            tmr_next  = '0;
                            tout_next = 1'b1;
                        end
                    end else begin
                        kind_next  = swcc_pkg::KIND_POP;
                        head_next  = head_inc;
                        cnt_next   = cnt_reg - 1'b1;
                        freed_next = CNT_W'(1);
                        if (cnt_reg != CNT_W'(1)) begin
                            state_next = ST_WALK;
                        end
                    end
                end
            end
            ST_GROW_DIV: begin
                if (div_rsp.done) begin
                    win_next   = (ca_sum > (WIN_W + 1)'(swcc_pkg::WIN_MAX))
                                 ? swcc_pkg::WIN_MAX : ca_sum[WIN_W-1:0];
                    state_next = ST_FINISH;
                end
            end
            ST_WALK: begin
                if (rd_seq == ack_reg) begin
                    tmr_next   = '0;
                    state_next = ST_FINISH;
                end else begin
                    head_next  = head_inc;
                    cnt_next   = cnt_reg - 1'b1;
                    freed_next = freed_reg + 1'b1;
                    if (cnt_reg == CNT_W'(1)) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({cnt_reg, thr_reg, win_reg, tout_reg,
                                            freed_reg, kind_reg, aseq_reg, acc_reg});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we) begin
            case (cfg_addr)
                swcc_pkg::CFG_INIT_WIN: begin
                    init_win_next = cfg_wdata[WIN_W-1:0];
                    win_next      = cfg_wdata[WIN_W-1:0];
                end
                swcc_pkg::CFG_INIT_THR: begin
                    init_thr_next = cfg_wdata[WIN_W-1:0];
                    thr_next      = cfg_wdata[WIN_W-1:0];
                end
                swcc_pkg::CFG_WIN_CAP:   win_cap_next   = cfg_wdata[WIN_W-1:0];
                swcc_pkg::CFG_SEG_BYTES: seg_next       = cfg_wdata[LEN_W-1:0];
                swcc_pkg::CFG_THR_FLOOR: thr_floor_next = cfg_wdata[WIN_W-1:0];
                swcc_pkg::CFG_TIMEOUT:   tmo_next       = cfg_wdata[TMR_W-1:0];
                swcc_pkg::CFG_FIRST_SEQ: begin
                    first_seq_next = cfg_wdata[SEQ_W-1:0];
                    nseq_next      = cfg_wdata[SEQ_W-1:0];
                end
                swcc_pkg::CFG_SEQ_MOD:   mod_next       = cfg_wdata[MOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            init_win_reg  <= swcc_pkg::RST_INIT_WIN;
            init_thr_reg  <= swcc_pkg::RST_INIT_THR;
            win_cap_reg   <= swcc_pkg::RST_WIN_CAP;
            seg_reg       <= swcc_pkg::RST_SEG_BYTES;
            thr_floor_reg <= swcc_pkg::RST_THR_FLOOR;
            tmo_reg       <= swcc_pkg::RST_TIMEOUT;
            first_seq_reg <= swcc_pkg::RST_FIRST_SEQ;
            mod_reg       <= swcc_pkg::RST_SEQ_MOD;
            win_reg       <= swcc_pkg::RST_INIT_WIN;
            thr_reg       <= swcc_pkg::RST_INIT_THR;
            nseq_reg      <= swcc_pkg::RST_FIRST_SEQ;
            tmr_reg       <= '0;
            head_reg      <= '0;
            cnt_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_win_reg  <= init_win_next;
            init_thr_reg  <= init_thr_next;
            win_cap_reg   <= win_cap_next;
            seg_reg       <= seg_next;
            thr_floor_reg <= thr_floor_next;
            tmo_reg       <= tmo_next;
            first_seq_reg <= first_seq_next;
            mod_reg       <= mod_next;
            win_reg       <= win_next;
            thr_reg       <= thr_next;
            nseq_reg      <= nseq_next;
            tmr_reg       <= tmr_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        op_reg      <= op_next;
        len_reg     <= len_next;
        ack_reg     <= ack_next;
        acc_reg     <= acc_next;
        aseq_reg    <= aseq_next;
        kind_reg    <= kind_next;
        freed_reg   <= freed_next;
        tout_reg    <= tout_next;
        m_tdata_reg <= m_tdata_next;
    end

    // ring memory; read port follows the head so the new head's entry is registered along with the head pointer
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= ring_mem[head_next];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ASSERT_CLK(a_cnt_bound, aclk, aresetn, cnt_reg <= DEPTH_C)
    `ASSERT_NEVER(a_div_overlap, aclk, aresetn, div_req.start && div_rsp.busy)
    `ASSERT_CLK(a_walk_nonempty, aclk, aresetn, (state_reg == ST_WALK) |-> (cnt_reg != '0))
    `ASSERT_CLK(a_send_op, aclk, aresetn,
                (state_reg == ST_SEND_DIV) |-> (op_reg == swcc_pkg::OP_SEND))
    `ASSERT_CLK(a_acc_clean, aclk, aresetn,
                (state_reg == ST_FINISH && acc_reg) |-> (kind_reg == swcc_pkg::KIND_NONE
                                                         && !tout_reg))
endmodule
`default_nettype wire
